>>> hw/rtl/ssag_pkg.sv
// Package for the spiral scan address generator: widths, request/result types and the microcode.
package ssag_pkg;

    localparam int MAX_SIDE   = 1024;
    localparam int CNT_W      = 11;                       // width of a grid side register
    localparam int CELL_W     = 10;                       // width of a cell coordinate
    localparam int POS_W      = 13;                       // signed walk position
    localparam int LEG_W      = 12;                       // leg length and progress
    localparam int EMIT_W     = 21;                       // emitted cell count
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [CNT_W-1:0] SIDE_LIMIT = CNT_W'(MAX_SIDE);

    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    typedef enum logic [1:0] {
        HEAD_EAST  = 2'd0,
        HEAD_SOUTH = 2'd1,
        HEAD_WEST  = 2'd2,
        HEAD_NORTH = 2'd3
    } t_heading;

    typedef struct packed {
        logic              op;
        logic [CELL_W-1:0] start_row;
        logic [CELL_W-1:0] start_col;
    } t_req;

    typedef struct packed {
        logic [CELL_W-1:0] cell_row;
        logic [CELL_W-1:0] cell_col;
        logic              last_cell;
        logic              valid_res;
    } t_res;

    typedef enum logic [2:0] {
        ST_FETCH     = 3'd0,
        ST_DISPATCH  = 3'd1,
        ST_NEXT_CHK  = 3'd2,
        ST_ADVANCE   = 3'd3,
        ST_EMIT_NEXT = 3'd4,
        ST_START_CHK = 3'd5,
        ST_LOAD_EMIT = 3'd6,
        ST_EMIT_INV  = 3'd7
    } t_step;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_OP_START,
        C_NOT_ACTIVE,
        C_ADV_OUT,
        C_START_OUT
    } t_cond;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_FETCH,
        DP_ADVANCE,
        DP_EMIT_NEXT,
        DP_LOAD_EMIT,
        DP_EMIT_INV
    } t_dp;

    typedef struct packed {
        logic  wait_in;
        logic  wait_out;
        t_dp   dp;
        t_cond cond;
        t_step target;
    } t_uword;

    // Control store: a taken condition jumps to target, otherwise the step counter moves on.
    function automatic t_uword ucode(input t_step a);
        t_uword w;
        w = '{wait_in: 1'b0, wait_out: 1'b0, dp: DP_NONE, cond: C_NEVER, target: ST_FETCH};
        unique case (a)
            ST_FETCH: begin
                w.wait_in = 1'b1;
                w.dp      = DP_FETCH;
            end
            ST_DISPATCH: begin
                w.cond   = C_OP_START;
                w.target = ST_START_CHK;
            end
            ST_NEXT_CHK: begin
                w.cond   = C_NOT_ACTIVE;
                w.target = ST_EMIT_INV;
            end
            ST_ADVANCE: begin
                w.dp     = DP_ADVANCE;
                w.cond   = C_ADV_OUT;
                w.target = ST_ADVANCE;
            end
            ST_EMIT_NEXT: begin
                w.wait_out = 1'b1;
                w.dp       = DP_EMIT_NEXT;
                w.cond     = C_ALWAYS;
                w.target   = ST_FETCH;
            end
            ST_START_CHK: begin
                w.cond   = C_START_OUT;
                w.target = ST_EMIT_INV;
            end
            ST_LOAD_EMIT: begin
                w.wait_out = 1'b1;
                w.dp       = DP_LOAD_EMIT;
                w.cond     = C_ALWAYS;
                w.target   = ST_FETCH;
            end
            ST_EMIT_INV: begin
                w.wait_out = 1'b1;
                w.dp       = DP_EMIT_INV;
                w.cond     = C_ALWAYS;
                w.target   = ST_FETCH;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = ST_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/spiral_scan_address_generator.sv
// Top level of the spiral scan address generator: microcoded sequencer, walk datapath, APB registers.
//
// Usage: a request on the input channel either starts a walk (op 0) at start_row/start_col
// or asks for the next cell of the clockwise square spiral (op 1). Each request gives
// exactly one result on the output channel; valid_res is 0 when no cell is produced.
// The grid size is set through the APB port: row_count at address 0, col_count at 4.
// Writing either register ends any walk in progress.
// Sequence: a request is taken in the fetch step. A start passes the dispatch and start-check
// steps to its emit step and the output register, whether it is accepted or rejected; a next
// request when no walk is active does so through the dispatch and next-check steps. A next
// request in a walk adds k advance steps after those, where k >= 1 is the number of single-cell
// moves the spiral makes to reach the next cell inside the grid; one move is made per cycle, so
// legs that run outside the grid lengthen k. The sequencer is back in the fetch step the cycle
// after its emit step.
// A request is accepted only in the fetch step, one at a time.
// The result sits in an output register; the sequencer fetches and works on the next
// request while it waits, and only holds at its emit step if the register is still full.
// A stalled result holds its payload.
// Reset sets both grid sides to 1, clears the walk and empties the output register.
module spiral_scan_address_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ssag_pkg::t_req                i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ssag_pkg::t_res                o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssag_pkg::PADDR_W-1:0]  paddr,
    input  logic [ssag_pkg::PDATA_W-1:0]  pwdata,
    output logic [ssag_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ssag_pkg::*;

    // Configuration registers and derived grid size.
    logic [CNT_W-1:0]  r_rows, r_cols;
    logic [CNT_W-1:0]  eff_rows, eff_cols;
    logic [EMIT_W-1:0] r_total;
    logic              cfg_wr;

    // Sequencer.
    t_step  r_upc;
    t_uword uw;
    logic   hold, taken;

    // Walk state.
    t_req               r_req;
    logic [POS_W-1:0]   r_pos_row, r_pos_col;
    logic [LEG_W-1:0]   r_leg_len, r_leg_prog;
    logic               r_second;
    t_heading           r_heading;
    logic [EMIT_W-1:0]  r_count;
    logic               r_active;

    // Output register.
    logic  r_out_valid;
    t_res  r_out;

    logic [POS_W-1:0]  adv_row, adv_col;
    logic [LEG_W-1:0]  prog_inc;
    logic              leg_done;
    logic              adv_in_grid, start_in_grid;
    logic [EMIT_W-1:0] count_inc;
    logic              out_busy;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? PDATA_W'(r_cols) : PDATA_W'(r_rows);

    assign eff_rows = (r_rows > SIDE_LIMIT) ? SIDE_LIMIT : r_rows;
    assign eff_cols = (r_cols > SIDE_LIMIT) ? SIDE_LIMIT : r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CNT_W'(1);
            r_cols <= CNT_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_cols <= pwdata[CNT_W-1:0];
            end else begin
                r_rows <= pwdata[CNT_W-1:0];
            end
        end
    end

    // The grid area is registered off the multiplier; it follows a side write in the next cycle.
    always_ff @(posedge i_clk) begin
        r_total <= EMIT_W'(eff_rows) * EMIT_W'(eff_cols);
    end

    // Single move along the current heading.
    always_comb begin
        adv_row = r_pos_row;
        adv_col = r_pos_col;
        case (r_heading)
            HEAD_EAST:  adv_col = r_pos_col + POS_W'(1);
            HEAD_SOUTH: adv_row = r_pos_row + POS_W'(1);
            HEAD_WEST:  adv_col = r_pos_col - POS_W'(1);
            default:    adv_row = r_pos_row - POS_W'(1);
        endcase
    end

    assign prog_inc      = r_leg_prog + LEG_W'(1);
    assign leg_done      = prog_inc >= r_leg_len;
    assign adv_in_grid   = !adv_row[POS_W-1] && !adv_col[POS_W-1]
                         && (adv_row[POS_W-2:0] < (POS_W-1)'(eff_rows))
                         && (adv_col[POS_W-2:0] < (POS_W-1)'(eff_cols));
    assign start_in_grid = (CNT_W'(r_req.start_row) < eff_rows)
                         && (CNT_W'(r_req.start_col) < eff_cols);
    assign count_inc     = r_count + EMIT_W'(1);
    assign out_busy      = r_out_valid && i_out_stall;

    assign uw   = ucode(r_upc);
    assign hold = (uw.wait_in && !i_in_valid) || (uw.wait_out && out_busy);

    always_comb begin
        case (uw.cond)
            C_ALWAYS:     taken = 1'b1;
            C_OP_START:   taken = (r_req.op == OP_START);
            C_NOT_ACTIVE: taken = !r_active;
            C_ADV_OUT:    taken = !adv_in_grid;
            C_START_OUT:  taken = !start_in_grid;
            default:      taken = 1'b0;
        endcase
    end

    assign o_in_stall = !uw.wait_in;

    // Step counter, walk control state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= ST_FETCH;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_leg_len   <= LEG_W'(1);
            r_leg_prog  <= '0;
            r_second    <= 1'b0;
            r_heading   <= HEAD_EAST;
            r_count     <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (!hold) begin
                r_upc <= taken ? uw.target : t_step'(r_upc + 3'd1);
                case (uw.dp)
                    DP_ADVANCE: begin
                        if (leg_done) begin
                            r_leg_prog <= '0;
                            r_heading  <= t_heading'(r_heading + 2'd1);
                            r_second   <= !r_second;
                            if (r_second) begin
                                r_leg_len <= r_leg_len + LEG_W'(1);
                            end
                        end else begin
                            r_leg_prog <= prog_inc;
                        end
                    end
                    DP_EMIT_NEXT: begin
                        r_count     <= count_inc;
                        r_active    <= count_inc < r_total;
                        r_out_valid <= 1'b1;
                    end
                    DP_LOAD_EMIT: begin
                        r_leg_len   <= LEG_W'(1);
                        r_leg_prog  <= '0;
                        r_second    <= 1'b0;
                        r_heading   <= HEAD_EAST;
                        r_count     <= EMIT_W'(1);
                        r_active    <= EMIT_W'(1) < r_total;
                        r_out_valid <= 1'b1;
                    end
                    DP_EMIT_INV: begin
                        r_active    <= 1'b0;
                        r_out_valid <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (cfg_wr) begin
                r_active <= 1'b0;
            end
        end
    end

    // Payload registers: request copy, position and result.
    always_ff @(posedge i_clk) begin
        if (!hold) begin
            case (uw.dp)
                DP_FETCH: begin
                    r_req <= i_in_data;
                end
                DP_ADVANCE: begin
                    r_pos_row <= adv_row;
                    r_pos_col <= adv_col;
                end
                DP_EMIT_NEXT: begin
                    r_out.cell_row  <= r_pos_row[CELL_W-1:0];
                    r_out.cell_col  <= r_pos_col[CELL_W-1:0];
                    r_out.last_cell <= count_inc >= r_total;
                    r_out.valid_res <= 1'b1;
                end
                DP_LOAD_EMIT: begin
                    r_pos_row       <= POS_W'(r_req.start_row);
                    r_pos_col       <= POS_W'(r_req.start_col);
                    r_out.cell_row  <= r_req.start_row;
                    r_out.cell_col  <= r_req.start_col;
                    r_out.last_cell <= EMIT_W'(1) >= r_total;
                    r_out.valid_res <= 1'b1;
                end
                DP_EMIT_INV: begin
                    r_out <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // Only one request is in flight: the sequencer leaves the fetch step right after a take.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while another is in flight");

    // A result with no cell carries zero fields.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.valid_res) |->
        (r_out.cell_row == '0 && r_out.cell_col == '0 && !r_out.last_cell))
        else $error("result without a cell has nonzero fields");

    // Leg progress always stays below the leg length.
    a_leg_prog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leg_prog < r_leg_len)
        else $error("leg progress reached leg length");

    // A new result only appears from one of the emit steps.
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |->
        ($past(r_upc) == ST_EMIT_NEXT || $past(r_upc) == ST_LOAD_EMIT
         || $past(r_upc) == ST_EMIT_INV))
        else $error("result appeared outside an emit step");

    // Once the last cell has been delivered, no walk remains active.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && r_out.last_cell) |-> !r_active)
        else $error("walk still active after the last cell");
`endif

endmodule

>>> sim/tb.sv
// Self-checking testbench for the spiral scan address generator.
`timescale 1ns / 1ps

module tb;
    import ssag_pkg::*;

    localparam int REG_ROW_COUNT = 0;
    localparam int REG_COL_COUNT = 1;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int SMALL_SIDE    = 12;
    localparam int IDLE_PCT      = 14;
    localparam int DRAIN_CYCLES  = 50;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // Tracks the spiral walk and holds the cells the block should produce, oldest first.
    class spiral_scoreboard;
        t_res            expected_q[$];
        int unsigned     mismatches;
        logic [CNT_W-1:0] rows_reg;
        logic [CNT_W-1:0] cols_reg;
        int              pos_r;
        int              pos_c;
        int unsigned     leg_len;
        int unsigned     leg_prog;
        bit              second_leg;
        t_heading        head;
        int unsigned     emitted;
        bit              walk_live;

        function new();
            mismatches = 0;
            rows_reg   = CNT_W'(1);
            cols_reg   = CNT_W'(1);
            pos_r      = 0;
            pos_c      = 0;
            leg_len    = 1;
            leg_prog   = 0;
            second_leg = 0;
            head       = HEAD_EAST;
            emitted    = 0;
            walk_live  = 0;
        endfunction

        function void report(string what);
            $display("error at %0t: %s", $time, what);
            mismatches++;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Sides above the cell field reach are clipped, so 2047 acts as 1024.
        function int unsigned grid_rows();
            return (rows_reg > MAX_SIDE) ? MAX_SIDE : rows_reg;
        endfunction

        function int unsigned grid_cols();
            return (cols_reg > MAX_SIDE) ? MAX_SIDE : cols_reg;
        endfunction

        function void write_side(int idx, logic [CNT_W-1:0] value);
            if (idx == REG_ROW_COUNT) begin
                rows_reg = value;
            end else begin
                cols_reg = value;
            end
            walk_live = 0;
        endfunction

        function bit on_grid(int r, int c, int unsigned rows, int unsigned cols);
            return r >= 0 && c >= 0 && r < int'(rows) && c < int'(cols);
        endfunction

        function void step_once();
            case (head)
                HEAD_EAST:  pos_c++;
                HEAD_SOUTH: pos_r++;
                HEAD_WEST:  pos_c--;
                default:    pos_r--;
            endcase
            leg_prog++;
            if (leg_prog >= leg_len) begin
                leg_prog = 0;
                head     = t_heading'((head + 1) % 4);
                if (second_leg) begin
                    leg_len++;
                    second_leg = 0;
                end else begin
                    second_leg = 1;
                end
            end
        endfunction

        function t_res cell_result(int unsigned total);
            t_res res;
            res.cell_row  = CELL_W'(pos_r);
            res.cell_col  = CELL_W'(pos_c);
            res.last_cell = (emitted >= total);
            res.valid_res = 1'b1;
            return res;
        endfunction

        function void note_request(t_req req);
            int unsigned rows;
            int unsigned cols;
            int unsigned total;
            t_res        res;
            rows  = grid_rows();
            cols  = grid_cols();
            total = rows * cols;
            res   = '0;
            if (req.op == OP_START) begin
                walk_live = 0;
                if (on_grid(int'(req.start_row), int'(req.start_col), rows, cols)) begin
                    pos_r      = int'(req.start_row);
                    pos_c      = int'(req.start_col);
                    leg_len    = 1;
                    leg_prog   = 0;
                    second_leg = 0;
                    head       = HEAD_EAST;
                    emitted    = 1;
                    walk_live  = (emitted < total);
                    res        = cell_result(total);
                end
            end else if (walk_live) begin
                do begin
                    step_once();
                end while (!on_grid(pos_r, pos_c, rows, cols));
                emitted++;
                walk_live = (emitted < total);
                res       = cell_result(total);
            end
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected cell %0d,%0d", got.cell_row, got.cell_col));
                return;
            end
            want = expected_q.pop_front();
            if (got.valid_res !== want.valid_res)
                report($sformatf("valid_res %b, expected %b", got.valid_res, want.valid_res));
            if (got.cell_row !== want.cell_row)
                report($sformatf("cell_row %0d, expected %0d", got.cell_row, want.cell_row));
            if (got.cell_col !== want.cell_col)
                report($sformatf("cell_col %0d, expected %0d", got.cell_col, want.cell_col));
            if (got.last_cell !== want.last_cell)
                report($sformatf("last_cell %b, expected %b", got.last_cell, want.last_cell));
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_req                i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_res                o_out_data;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    spiral_scoreboard sb = new();
    int  sent_items = 0;
    int  cycles     = 0;
    bit  idle_on    = 1'b1;

    spiral_scan_address_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: check every accepted cell, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_data);
        i_out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic send_req(input logic op, input int row, input int col);
        t_req req;
        req.op        = op;
        req.start_row = CELL_W'(row);
        req.start_col = CELL_W'(col);
        if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req);
        sent_items++;
    endtask

    task automatic send_start(input int row, input int col);
        send_req(OP_START, row, col);
    endtask

    // The start fields are ignored on a next request, so they carry noise.
    task automatic send_next();
        send_req(OP_NEXT, $urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    // Drop the request line and wait until every expected cell has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_side(input int idx, input logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * idx);
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_side(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CNT_W-1:0] pick_side();
        case ($urandom_range(0, 5))
            0:       return CNT_W'(0);
            1:       return CNT_W'(1);
            2:       return CNT_W'(MAX_SIDE);
            3:       return {CNT_W{1'b1}};
            4:       return CNT_W'($urandom_range(MAX_SIDE + 1, 2046));
            default: return CNT_W'($urandom_range(0, 2047));
        endcase
    endfunction

    initial begin
        int          base;
        int unsigned gr;
        int unsigned gc;
        int unsigned n;
        logic [CNT_W-1:0] rv;
        logic [CNT_W-1:0] cv;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: out-of-reset behavior on the one-cell grid.
        send_next();
        send_start(0, 0);
        send_next();
        send_start(1023, 1023);
        send_start(0, 1);

        // A zero side leaves the grid empty.
        settle();
        write_side(REG_ROW_COUNT, CNT_W'(0));
        write_side(REG_COL_COUNT, CNT_W'(5));
        send_start(0, 0);

        // Full 3x3 walk from the center, then one request past the end.
        settle();
        write_side(REG_ROW_COUNT, CNT_W'(3));
        write_side(REG_COL_COUNT, CNT_W'(3));
        send_start(1, 1);
        repeat (9) send_next();

        // Oversized sides clip to the field reach.
        settle();
        write_side(REG_ROW_COUNT, {CNT_W{1'b1}});
        write_side(REG_COL_COUNT, CNT_W'(MAX_SIDE));
        send_start(1023, 1023);
        repeat (3) send_next();
        send_start(0, 0);
        repeat (2) send_next();

        // A register write ends the walk that is still open.
        settle();
        write_side(REG_ROW_COUNT, CNT_W'(4));
        send_next();
        send_start(3, 1023);

        base = sent_items;
        while (sent_items - base < RANDOM_ITEMS) begin
            settle();
            if ($urandom_range(0, 99) < 85) begin
                rv = CNT_W'($urandom_range(1, SMALL_SIDE));
                cv = CNT_W'($urandom_range(1, SMALL_SIDE));
            end else begin
                rv = pick_side();
                cv = pick_side();
            end
            case ($urandom_range(0, 9))
                0:       write_side(REG_ROW_COUNT, rv);
                1:       write_side(REG_COL_COUNT, cv);
                default: begin
                    write_side(REG_ROW_COUNT, rv);
                    write_side(REG_COL_COUNT, cv);
                end
            endcase
            gr = sb.grid_rows();
            gc = sb.grid_cols();

            repeat ($urandom_range(1, 4)) begin
                n = sent_items - base;
                idle_on <= !(n >= 800 && n < 1200);
                if ($urandom_range(0, 99) < 10) begin
                    if ($urandom_range(0, 1))
                        send_next();
                    else
                        send_start($urandom_range(0, 1023), $urandom_range(0, 1023));
                end else if (gr == 0 || gc == 0) begin
                    send_start($urandom_range(0, 1023), $urandom_range(0, 1023));
                end else begin
                    send_start($urandom_range(0, gr - 1), $urandom_range(0, gc - 1));
                    if (gr > SMALL_SIDE || gc > SMALL_SIDE) begin
                        // Large grids take long spiral legs, so only a short stretch is walked.
                        repeat ($urandom_range(0, 20)) send_next();
                    end else if ($urandom_range(0, 99) < 70) begin
                        while (sb.walk_live) send_next();
                        if ($urandom_range(0, 1))
                            send_next();
                    end else begin
                        repeat ($urandom_range(0, gr * gc)) send_next();
                    end
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected cells never arrived", sb.pending()));
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
